/* sv/omni_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// omni_pkg
// Shared constants and pipeline stage types for the omnidirectional
// undistort-rectify map core.
// ----------------------------------------------------------------------------
package omni_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_RAY_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAY_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAY_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SKEW   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LENS   = 3'd6;

    localparam int RAY_ROW_W = 63;
    localparam int COEF_W    = 21;

    // arithmetic widths
    localparam int NORM_W  = 29;   // normalised ray magnitude
    localparam int SQ_IN_W = 60;   // sum of squares
    localparam int ROOT_W  = 30;   // integer square root
    localparam int REM_W   = 33;   // square root partial remainder
    localparam int DEN_W   = 63;   // positive projection denominator
    localparam int DREM_W  = 64;   // division partial remainder
    localparam int Q_W     = 23;   // projected magnitude, Q.20 below 8.0
    localparam int FRAC    = 20;

    localparam logic signed [30:0] XD_LIMIT = 31'sh3FFF_FFFF;

    // square root stage
    typedef struct packed {
        logic                     valid;
        logic                     fail;
        logic [SQ_IN_W-1:0]       n;
        logic [REM_W-1:0]         rem;
        logic [ROOT_W-1:0]        root;
        logic [NORM_W-1:0]        nx;
        logic [NORM_W-1:0]        ny;
        logic signed [NORM_W:0]   z;
        logic                     sx;
        logic                     sy;
    } t_sq;

    // projection divider stage
    typedef struct packed {
        logic               valid;
        logic               fail;
        logic [DEN_W-1:0]   den;
        logic [DREM_W-1:0]  remx;
        logic [DREM_W-1:0]  remy;
        logic [Q_W-1:0]     qx;
        logic [Q_W-1:0]     qy;
        logic               sx;
        logic               sy;
    } t_dv;

endpackage
`default_nettype wire

/* sv/omni_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// omni interfaces
// Pixel, map result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface omni_pix_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_column;
    logic [COORD_BITS-1:0] pixel_row;

    modport source (output valid, output pixel_column, output pixel_row, input ready);
    modport sink   (input valid, input pixel_column, input pixel_row, output ready);
endinterface

interface omni_map_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] source_u;
    logic signed [31:0] source_v;
    logic               map_invalid;

    modport source (output valid, output source_u, output source_v, output map_invalid,
                    input ready);
    modport sink   (input valid, input source_u, input source_v, input map_invalid,
                    output ready);
endinterface

interface omni_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [omni_pkg::CFG_IDX_W-1:0]  index;
    logic [omni_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* sv/omni_undistort_rectify_map_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// omni_undistort_rectify_map_core
// Unified omnidirectional camera undistort-rectify map, one pixel per clock while o_map is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//  i_pix carries a rectified pixel (column, row); o_map returns the source
//  coordinates u, v in signed Q16.16 and an invalid flag for that pixel.
//  i_cfg writes the seven model registers by index; it is always ready and
//  must only be used while no pixel is in flight.
//  From the accepting edge to the result word on o_map, a word passes
//  five front stages (ray, magnitude, normalise, squares, sum), 30 square
//  root stages of one root bit each, two denominator stages, 23 divider
//  stages of one quotient bit each, eight distortion/intrinsic stages and
//  the output register.
//  Throughput is one word per clock. When o_map stalls, the whole pipeline
//  holds and i_pix.ready drops; nothing is lost or repeated, and a new word
//  is still taken while the output register drains.
//  Synchronous active-low reset clears all valid bits and all model
//  registers to zero.
// ----------------------------------------------------------------------------
module omni_undistort_rectify_map_core #(
    parameter int COORD_BITS = 12
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    omni_pix_if.sink   i_pix,
    omni_map_if.source o_map,
    omni_cfg_if.sink   i_cfg
);
    import omni_pkg::*;

    localparam int RW = COEF_W + COORD_BITS + 3;
    localparam int LW = $clog2(RW + 1);

    // model registers
    logic [RAY_ROW_W-1:0] r_ray_x, r_ray_y, r_ray_z;
    logic [63:0]          r_focal, r_center, r_skew, r_lens;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ray_x  <= '0;
            r_ray_y  <= '0;
            r_ray_z  <= '0;
            r_focal  <= '0;
            r_center <= '0;
            r_skew   <= '0;
            r_lens   <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_RAY_X:  r_ray_x  <= i_cfg.data[RAY_ROW_W-1:0];
                REG_RAY_Y:  r_ray_y  <= i_cfg.data[RAY_ROW_W-1:0];
                REG_RAY_Z:  r_ray_z  <= i_cfg.data[RAY_ROW_W-1:0];
                REG_FOCAL:  r_focal  <= i_cfg.data;
                REG_CENTER: r_center <= i_cfg.data;
                REG_SKEW:   r_skew   <= i_cfg.data;
                REG_LENS:   r_lens   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // global pipeline advance
    logic adv;
    logic r_out_valid;
    assign adv         = !r_out_valid || o_map.ready;
    assign i_pix.ready = adv;

    // stage 1: ray components
    logic                 r_s1_valid;
    logic signed [RW-1:0] r_s1_x, r_s1_y, r_s1_z;
    logic signed [RW-1:0] n_s1_x, n_s1_y, n_s1_z;
    logic signed [COORD_BITS:0] pc, pr;

    assign pc = $signed({1'b0, i_pix.pixel_column});
    assign pr = $signed({1'b0, i_pix.pixel_row});

    assign n_s1_x = $signed(r_ray_x[62:42]) * pc + $signed(r_ray_x[41:21]) * pr
                  + $signed(r_ray_x[20:0]);
    assign n_s1_y = $signed(r_ray_y[62:42]) * pc + $signed(r_ray_y[41:21]) * pr
                  + $signed(r_ray_y[20:0]);
    assign n_s1_z = $signed(r_ray_z[62:42]) * pc + $signed(r_ray_z[41:21]) * pr
                  + $signed(r_ray_z[20:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_pix.valid;
            r_s1_x     <= n_s1_x;
            r_s1_y     <= n_s1_y;
            r_s1_z     <= n_s1_z;
        end
    end

    // stage 2: magnitudes and bit length of the largest
    logic          r_s2_valid;
    logic [RW-1:0] r_s2_mx, r_s2_my, r_s2_mz;
    logic          r_s2_sx, r_s2_sy, r_s2_sz;
    logic [LW-1:0] r_s2_len;
    logic [RW-1:0] n_s2_mx, n_s2_my, n_s2_mz, mmax;
    logic [LW-1:0] n_s2_len;

    assign n_s2_mx = r_s1_x[RW-1] ? RW'(-r_s1_x) : RW'(r_s1_x);
    assign n_s2_my = r_s1_y[RW-1] ? RW'(-r_s1_y) : RW'(r_s1_y);
    assign n_s2_mz = r_s1_z[RW-1] ? RW'(-r_s1_z) : RW'(r_s1_z);

    always_comb begin
        mmax = n_s2_mx;
        if (n_s2_my > mmax) mmax = n_s2_my;
        if (n_s2_mz > mmax) mmax = n_s2_mz;
        n_s2_len = '0;
        for (int i = 0; i < RW; i++) begin
            if (mmax[i]) n_s2_len = LW'(i + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid;
            r_s2_mx    <= n_s2_mx;
            r_s2_my    <= n_s2_my;
            r_s2_mz    <= n_s2_mz;
            r_s2_sx    <= r_s1_x[RW-1];
            r_s2_sy    <= r_s1_y[RW-1];
            r_s2_sz    <= r_s1_z[RW-1];
            r_s2_len   <= n_s2_len;
        end
    end

    // stage 3: block normalisation to [2^28, 2^29)
    logic              r_s3_valid, r_s3_fail;
    logic [NORM_W-1:0] r_s3_nx, r_s3_ny, r_s3_nz;
    logic              r_s3_sx, r_s3_sy, r_s3_sz;
    logic [RW+NORM_W-1:0] shx, shy, shz;

    assign shx = {r_s2_mx, {NORM_W{1'b0}}} >> r_s2_len;
    assign shy = {r_s2_my, {NORM_W{1'b0}}} >> r_s2_len;
    assign shz = {r_s2_mz, {NORM_W{1'b0}}} >> r_s2_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s3_valid <= r_s2_valid;
            r_s3_fail  <= (r_s2_len == '0);
            r_s3_nx    <= shx[NORM_W-1:0];
            r_s3_ny    <= shy[NORM_W-1:0];
            r_s3_nz    <= shz[NORM_W-1:0];
            r_s3_sx    <= r_s2_sx;
            r_s3_sy    <= r_s2_sy;
            r_s3_sz    <= r_s2_sz;
        end
    end

    // stage 4: squares
    logic                   r_s4_valid, r_s4_fail;
    logic [2*NORM_W-1:0]    r_s4_qx, r_s4_qy, r_s4_qz;
    logic [NORM_W-1:0]      r_s4_nx, r_s4_ny;
    logic signed [NORM_W:0] r_s4_z;
    logic                   r_s4_sx, r_s4_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (adv) begin
            r_s4_valid <= r_s3_valid;
            r_s4_fail  <= r_s3_fail;
            r_s4_qx    <= r_s3_nx * r_s3_nx;
            r_s4_qy    <= r_s3_ny * r_s3_ny;
            r_s4_qz    <= r_s3_nz * r_s3_nz;
            r_s4_nx    <= r_s3_nx;
            r_s4_ny    <= r_s3_ny;
            r_s4_z     <= r_s3_sz ? -$signed({1'b0, r_s3_nz}) : $signed({1'b0, r_s3_nz});
            r_s4_sx    <= r_s3_sx;
            r_s4_sy    <= r_s3_sy;
        end
    end

    // stage 5: sum of squares, loaded into the square root pipe
    t_sq r_s5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5.valid <= 1'b0;
        end else if (adv) begin
            r_s5.valid <= r_s4_valid;
            r_s5.fail  <= r_s4_fail;
            r_s5.n     <= SQ_IN_W'(r_s4_qx) + SQ_IN_W'(r_s4_qy) + SQ_IN_W'(r_s4_qz);
            r_s5.rem   <= '0;
            r_s5.root  <= '0;
            r_s5.nx    <= r_s4_nx;
            r_s5.ny    <= r_s4_ny;
            r_s5.z     <= r_s4_z;
            r_s5.sx    <= r_s4_sx;
            r_s5.sy    <= r_s4_sy;
        end
    end

    // square root, one root bit per stage
    t_sq r_sq [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sq
        t_sq              src, nxt;
        logic [REM_W-1:0] rc, trial;

        if (k == 0) begin : g_first
            assign src = r_s5;
        end else begin : g_next
            assign src = r_sq[k-1];
        end

        assign rc    = {src.rem[REM_W-3:0], src.n[SQ_IN_W-1:SQ_IN_W-2]};
        assign trial = {1'b0, src.root, 2'b01};

        always_comb begin
            nxt   = src;
            nxt.n = {src.n[SQ_IN_W-3:0], 2'b00};
            if (rc >= trial) begin
                nxt.rem  = rc - trial;
                nxt.root = {src.root[ROOT_W-2:0], 1'b1};
            end else begin
                nxt.rem  = rc;
                nxt.root = {src.root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq[k].valid <= 1'b0;
            end else if (adv) begin
                r_sq[k] <= nxt;
            end
        end
    end

    // stage 6: denominator xi*|ray| + Z*2^28
    logic                   r_s6_valid, r_s6_fail;
    logic signed [63:0]     r_s6_den;
    logic [NORM_W-1:0]      r_s6_nx, r_s6_ny;
    logic                   r_s6_sx, r_s6_sy;
    logic [61:0]            xr;
    t_sq                    sq_out;

    assign sq_out = r_sq[ROOT_W-1];
    assign xr     = r_skew[31:0] * sq_out.root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else if (adv) begin
            r_s6_valid <= sq_out.valid;
            r_s6_fail  <= sq_out.fail;
            r_s6_den   <= $signed({2'b00, xr})
                        + $signed({{6{sq_out.z[NORM_W]}}, sq_out.z, 28'd0});
            r_s6_nx    <= sq_out.nx;
            r_s6_ny    <= sq_out.ny;
            r_s6_sx    <= sq_out.sx;
            r_s6_sy    <= sq_out.sy;
        end
    end

    // stage 7: denominator sign and range checks, divider load
    t_dv               r_s7;
    logic              den_bad, ovx, ovy;
    logic [DREM_W-1:0] ldx, ldy;

    assign den_bad = r_s6_den[63] || (r_s6_den == '0);
    assign ldx     = DREM_W'({r_s6_nx, 25'd0});
    assign ldy     = DREM_W'({r_s6_ny, 25'd0});
    assign ovx     = ldx >= {1'b0, r_s6_den[DEN_W-1:0]};
    assign ovy     = ldy >= {1'b0, r_s6_den[DEN_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7.valid <= 1'b0;
        end else if (adv) begin
            r_s7.valid <= r_s6_valid;
            r_s7.fail  <= r_s6_fail || den_bad || ovx || ovy;
            r_s7.den   <= r_s6_den[DEN_W-1:0];
            r_s7.remx  <= ldx;
            r_s7.remy  <= ldy;
            r_s7.qx    <= '0;
            r_s7.qy    <= '0;
            r_s7.sx    <= r_s6_sx;
            r_s7.sy    <= r_s6_sy;
        end
    end

    // projection divider, one quotient bit per stage for both axes
    t_dv r_dv [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_dv
        t_dv               src, nxt;
        logic [DREM_W-1:0] rx2, ry2, dext;
        logic              gex, gey;

        if (j == 0) begin : g_first
            assign src = r_s7;
        end else begin : g_next
            assign src = r_dv[j-1];
        end

        assign dext = {1'b0, src.den};
        assign rx2  = {src.remx[DREM_W-2:0], 1'b0};
        assign ry2  = {src.remy[DREM_W-2:0], 1'b0};
        assign gex  = rx2 >= dext;
        assign gey  = ry2 >= dext;

        always_comb begin
            nxt      = src;
            nxt.remx = gex ? rx2 - dext : rx2;
            nxt.remy = gey ? ry2 - dext : ry2;
            nxt.qx   = {src.qx[Q_W-2:0], gex};
            nxt.qy   = {src.qy[Q_W-2:0], gey};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j].valid <= 1'b0;
            end else if (adv) begin
                r_dv[j] <= nxt;
            end
        end
    end

    // stage A: signed projected point and its products
    t_dv                dv_out;
    logic signed [23:0] xu_n, yu_n;
    logic               r_sa_valid, r_sa_fail;
    logic signed [47:0] r_sa_xx, r_sa_yy, r_sa_xy;
    logic signed [23:0] r_sa_xu, r_sa_yu;

    assign dv_out = r_dv[Q_W-1];
    assign xu_n   = dv_out.sx ? -$signed({1'b0, dv_out.qx}) : $signed({1'b0, dv_out.qx});
    assign yu_n   = dv_out.sy ? -$signed({1'b0, dv_out.qy}) : $signed({1'b0, dv_out.qy});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa_valid <= 1'b0;
        end else if (adv) begin
            r_sa_valid <= dv_out.valid;
            r_sa_fail  <= dv_out.fail;
            r_sa_xx    <= xu_n * xu_n;
            r_sa_yy    <= yu_n * yu_n;
            r_sa_xy    <= xu_n * yu_n;
            r_sa_xu    <= xu_n;
            r_sa_yu    <= yu_n;
        end
    end

    // stage B: r2, xx, yy, xy back in Q.20
    logic signed [48:0] r2_sum, r2_sh;
    logic signed [47:0] xx_sh, yy_sh, xy_sh;
    logic               r_sb_valid, r_sb_fail;
    logic signed [27:0] r_sb_r2, r_sb_xx, r_sb_yy, r_sb_xy;
    logic signed [23:0] r_sb_xu, r_sb_yu;

    assign r2_sum = 49'(r_sa_xx) + 49'(r_sa_yy);
    assign r2_sh  = r2_sum >>> FRAC;
    assign xx_sh  = r_sa_xx >>> FRAC;
    assign yy_sh  = r_sa_yy >>> FRAC;
    assign xy_sh  = r_sa_xy >>> FRAC;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb_valid <= 1'b0;
        end else if (adv) begin
            r_sb_valid <= r_sa_valid;
            r_sb_fail  <= r_sa_fail;
            r_sb_r2    <= r2_sh[27:0];
            r_sb_xx    <= xx_sh[27:0];
            r_sb_yy    <= yy_sh[27:0];
            r_sb_xy    <= xy_sh[27:0];
            r_sb_xu    <= r_sa_xu;
            r_sb_yu    <= r_sa_yu;
        end
    end

    // stage C: radial and tangential coefficient products
    logic signed [15:0] k1, k2, p1, p2;
    logic signed [28:0] sxx, syy;
    logic signed [43:0] k1r, k2r, p1xy, p2xy, k1r_sh, k2r_sh, p1xy_sh, p2xy_sh;
    logic signed [44:0] p2s, p1s, p2s_sh, p1s_sh;
    logic               r_sc_valid, r_sc_fail;
    logic signed [29:0] r_sc_ra, r_sc_t;
    logic signed [30:0] r_sc_tx1, r_sc_tx2, r_sc_ty1, r_sc_ty2;
    logic signed [27:0] r_sc_r2;
    logic signed [23:0] r_sc_xu, r_sc_yu;

    assign k1 = $signed(r_lens[63:48]);
    assign k2 = $signed(r_lens[47:32]);
    assign p1 = $signed(r_lens[31:16]);
    assign p2 = $signed(r_lens[15:0]);

    assign sxx     = 29'(r_sb_r2) + (29'(r_sb_xx) <<< 1);
    assign syy     = 29'(r_sb_r2) + (29'(r_sb_yy) <<< 1);
    assign k1r     = k1 * r_sb_r2;
    assign k2r     = k2 * r_sb_r2;
    assign p1xy    = p1 * r_sb_xy;
    assign p2xy    = p2 * r_sb_xy;
    assign p2s     = p2 * sxx;
    assign p1s     = p1 * syy;
    assign k1r_sh  = k1r >>> 14;
    assign k2r_sh  = k2r >>> 14;
    // doubling before a shift by 14 is a shift by 13
    assign p1xy_sh = p1xy >>> 13;
    assign p2xy_sh = p2xy >>> 13;
    assign p2s_sh  = p2s >>> 14;
    assign p1s_sh  = p1s >>> 14;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_valid <= 1'b0;
        end else if (adv) begin
            r_sc_valid <= r_sb_valid;
            r_sc_fail  <= r_sb_fail;
            r_sc_ra    <= k1r_sh[29:0];
            r_sc_t     <= k2r_sh[29:0];
            r_sc_tx1   <= p1xy_sh[30:0];
            r_sc_tx2   <= p2s_sh[30:0];
            r_sc_ty1   <= p2xy_sh[30:0];
            r_sc_ty2   <= p1s_sh[30:0];
            r_sc_r2    <= r_sb_r2;
            r_sc_xu    <= r_sb_xu;
            r_sc_yu    <= r_sb_yu;
        end
    end

    // stage D: second radial product, tangential sums
    logic               r_sd_valid, r_sd_fail;
    logic signed [57:0] r_sd_rb;
    logic signed [29:0] r_sd_ra;
    logic signed [31:0] r_sd_tx, r_sd_ty;
    logic signed [23:0] r_sd_xu, r_sd_yu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd_valid <= 1'b0;
        end else if (adv) begin
            r_sd_valid <= r_sc_valid;
            r_sd_fail  <= r_sc_fail;
            r_sd_rb    <= r_sc_t * r_sc_r2;
            r_sd_ra    <= r_sc_ra;
            r_sd_tx    <= 32'(r_sc_tx1) + 32'(r_sc_tx2);
            r_sd_ty    <= 32'(r_sc_ty1) + 32'(r_sc_ty2);
            r_sd_xu    <= r_sc_xu;
            r_sd_yu    <= r_sc_yu;
        end
    end

    // stage E: radial factor
    logic signed [57:0] rb_sh;
    logic               r_se_valid, r_se_fail;
    logic signed [39:0] r_se_radial;
    logic signed [31:0] r_se_tx, r_se_ty;
    logic signed [23:0] r_se_xu, r_se_yu;

    assign rb_sh = r_sd_rb >>> FRAC;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_se_valid <= 1'b0;
        end else if (adv) begin
            r_se_valid  <= r_sd_valid;
            r_se_fail   <= r_sd_fail;
            r_se_radial <= (40'sd1 <<< FRAC) + 40'(r_sd_ra) + $signed(rb_sh[39:0]);
            r_se_tx     <= r_sd_tx;
            r_se_ty     <= r_sd_ty;
            r_se_xu     <= r_sd_xu;
            r_se_yu     <= r_sd_yu;
        end
    end

    // stage F: radial scaling
    logic               r_sf_valid, r_sf_fail;
    logic signed [63:0] r_sf_px, r_sf_py;
    logic signed [31:0] r_sf_tx, r_sf_ty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sf_valid <= 1'b0;
        end else if (adv) begin
            r_sf_valid <= r_se_valid;
            r_sf_fail  <= r_se_fail;
            r_sf_px    <= r_se_radial * r_se_xu;
            r_sf_py    <= r_se_radial * r_se_yu;
            r_sf_tx    <= r_se_tx;
            r_sf_ty    <= r_se_ty;
        end
    end

    // stage G: distorted point with clamp
    logic signed [63:0] px_sh, py_sh;
    logic signed [44:0] xdf, ydf;
    logic signed [30:0] xd_c, yd_c;
    logic               xd_bad, yd_bad;
    logic               r_sg_valid, r_sg_fail, r_sg_bad;
    logic signed [30:0] r_sg_xd, r_sg_yd;

    assign px_sh = r_sf_px >>> FRAC;
    assign py_sh = r_sf_py >>> FRAC;
    assign xdf   = $signed(px_sh[44:0]) + 45'(r_sf_tx);
    assign ydf   = $signed(py_sh[44:0]) + 45'(r_sf_ty);

    always_comb begin
        xd_bad = 1'b1;
        yd_bad = 1'b1;
        if (xdf > 45'(XD_LIMIT))       xd_c = XD_LIMIT;
        else if (xdf < -45'(XD_LIMIT)) xd_c = -XD_LIMIT;
        else begin
            xd_c   = xdf[30:0];
            xd_bad = 1'b0;
        end
        if (ydf > 45'(XD_LIMIT))       yd_c = XD_LIMIT;
        else if (ydf < -45'(XD_LIMIT)) yd_c = -XD_LIMIT;
        else begin
            yd_c   = ydf[30:0];
            yd_bad = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sg_valid <= 1'b0;
        end else if (adv) begin
            r_sg_valid <= r_sf_valid;
            r_sg_fail  <= r_sf_fail;
            r_sg_bad   <= xd_bad || yd_bad;
            r_sg_xd    <= xd_c;
            r_sg_yd    <= yd_c;
        end
    end

    // stage H: intrinsics with skew
    logic signed [32:0] fx;
    logic signed [32:0] fy;
    logic signed [31:0] sk;
    logic               r_sh_valid, r_sh_fail, r_sh_bad;
    logic signed [64:0] r_sh_pu;
    logic signed [63:0] r_sh_pv;

    assign fx = $signed({1'b0, r_focal[63:32]});
    assign fy = $signed({1'b0, r_focal[31:0]});
    assign sk = $signed(r_skew[63:32]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh_valid <= 1'b0;
        end else if (adv) begin
            r_sh_valid <= r_sg_valid;
            r_sh_fail  <= r_sg_fail;
            r_sh_bad   <= r_sg_bad;
            r_sh_pu    <= 65'(fx * r_sg_xd) + 65'(sk * r_sg_yd);
            r_sh_pv    <= fy * r_sg_yd;
        end
    end

    // output register: centre offset and saturation
    logic signed [64:0] pu_sh;
    logic signed [63:0] pv_sh;
    logic signed [45:0] us;
    logic signed [44:0] vs;
    logic signed [31:0] u_sat, v_sat;
    logic               u_bad, v_bad;
    logic signed [31:0] r_out_u, r_out_v;
    logic               r_out_inv;

    assign pu_sh = r_sh_pu >>> FRAC;
    assign pv_sh = r_sh_pv >>> FRAC;
    assign us    = $signed(pu_sh[45:0]) + 46'($signed(r_center[63:32]));
    assign vs    = $signed(pv_sh[44:0]) + 45'($signed(r_center[31:0]));

    always_comb begin
        u_bad = 1'b1;
        v_bad = 1'b1;
        if (us > 46'sd2147483647)       u_sat = 32'sh7FFF_FFFF;
        else if (us < -46'sd2147483648) u_sat = 32'sh8000_0000;
        else begin
            u_sat = us[31:0];
            u_bad = 1'b0;
        end
        if (vs > 45'sd2147483647)       v_sat = 32'sh7FFF_FFFF;
        else if (vs < -45'sd2147483648) v_sat = 32'sh8000_0000;
        else begin
            v_sat = vs[31:0];
            v_bad = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_sh_valid;
            r_out_u     <= r_sh_fail ? 32'sh8000_0000 : u_sat;
            r_out_v     <= r_sh_fail ? 32'sh8000_0000 : v_sat;
            r_out_inv   <= r_sh_fail || r_sh_bad || u_bad || v_bad;
        end
    end

    assign o_map.valid       = r_out_valid;
    assign o_map.source_u    = r_out_u;
    assign o_map.source_v    = r_out_v;
    assign o_map.map_invalid = r_out_inv;

`ifndef ASSERT_OFF
    // an accepted word enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_s1_valid)
        else $error("accepted pixel word did not enter the pipeline");

    // divider remainder stays below the denominator for a good word
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dv_out.valid && !dv_out.fail) |->
            (dv_out.remx < {1'b0, dv_out.den} && dv_out.remy < {1'b0, dv_out.den}))
        else $error("projection divider remainder out of range");

    // clamped distorted point stays inside the limit
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sg_valid |-> (r_sg_xd != 31'sh4000_0000 && r_sg_yd != 31'sh4000_0000))
        else $error("distorted point outside clamp range");

    // a stall freezes the pipeline
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_sh_valid) && $stable(r_s1_valid)))
        else $error("pipeline moved while the output was stalled");
`endif

endmodule
`default_nettype wire
